// ===== rtl/core/eiup_pkg.sv =====
// Package for the Ethernet/IPv4/UDP header parser.
// Holds status codes, header offsets and the result item types.
// No dependencies.
package eiup_pkg;

  typedef enum logic [3:0] {
    ST_UDP         = 4'd0,
    ST_ARP         = 4'd1,
    ST_OTHER_ETH   = 4'd2,
    ST_BAD_VER     = 4'd3,
    ST_BAD_HLEN    = 4'd4,
    ST_TRUNC       = 4'd5,
    ST_TCP         = 4'd6,
    ST_ICMP        = 4'd7,
    ST_OTHER_PROTO = 4'd8,
    ST_RUNT        = 4'd9
  } status_t;

  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_ARP  = 16'h0806;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  localparam logic [3:0] IP_VERSION4  = 4'd4;
  localparam logic [3:0] IP_MIN_WORDS = 4'd5;

  localparam logic [15:0] OFF_TYPE_HI  = 16'd12;
  localparam logic [15:0] OFF_TYPE_LO  = 16'd13;
  localparam logic [15:0] OFF_VER_IHL  = 16'd14;
  localparam logic [15:0] OFF_TLEN_HI  = 16'd16;
  localparam logic [15:0] OFF_TLEN_LO  = 16'd17;
  localparam logic [15:0] OFF_PROTO    = 16'd23;
  localparam logic [15:0] OFF_UDP_MIN  = 16'd24;
  localparam logic [15:0] OFF_SRC_FIRST = 16'd26;
  localparam logic [15:0] OFF_SRC_LAST  = 16'd29;
  localparam logic [15:0] OFF_SAT      = 16'hFFFF;

  localparam logic [15:0] ETH_HDR_BYTES = 16'd14;
  localparam logic [15:0] UDP_HDR_BYTES = 16'd8;
  localparam logic [15:0] UDP_PORT_HI   = 16'd0;
  localparam logic [15:0] UDP_PORT_LO   = 16'd1;
  localparam logic [15:0] UDP_LEN_HI    = 16'd4;
  localparam logic [15:0] UDP_LEN_LO    = 16'd5;

  localparam int NUM_COUNTERS = 5;
  localparam int CNT_UDP     = 0;
  localparam int CNT_TCP     = 1;
  localparam int CNT_ICMP    = 2;
  localparam int CNT_ARP     = 3;
  localparam int CNT_UNKNOWN = 4;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic        end_of_run;
    status_t     status;
    logic [31:0] source_address;
    logic [15:0] source_port;
    logic [15:0] payload_length;
    logic [31:0] udp_total;
    logic [31:0] tcp_total;
    logic [31:0] icmp_total;
    logic [31:0] arp_total;
    logic [31:0] unknown_total;
  } result_t;

  // Up to two result items produced by one input item, item 0 first.
  typedef struct packed {
    logic [1:0]    count;
    result_t [1:0] item;
  } push_t;

endpackage

// ===== rtl/core/eiup_parse.sv =====
// Header parse stage: frame state, field capture, classification, counters.
// Produces up to two result items per accepted byte. Depends on eiup_pkg.
module eiup_parse
  import eiup_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  data_byte,
  input  logic        frame_start,
  input  logic        frame_end,
  input  logic [15:0] frame_length,
  output push_t       push
);

  logic [15:0] byte_offset;
  logic [15:0] wire_length;
  logic [15:0] ether_type;
  logic [3:0]  header_words;
  logic [7:0]  ip_len_hi;
  logic [31:0] src_address_reg;
  logic [15:0] src_port_reg;
  logic [15:0] udp_length;
  status_t     frame_status;
  logic [31:0] packet_counters [NUM_COUNTERS];

  logic [15:0] off;
  logic [15:0] wl;
  logic [15:0] et;
  logic [3:0]  hw;
  logic [7:0]  tl_hi;
  logic [31:0] src_a;
  logic [15:0] src_p;
  logic [15:0] ulen;
  status_t     st;
  status_t     fst;
  logic        active;
  logic        ipv4;
  logic        is_ip;
  logic        udp_live;
  logic        pay;
  logic [15:0] hdr;
  logic [15:0] plen;
  logic [16:0] pstart;
  logic [15:0] off_next;
  logic [31:0] cnt_next [NUM_COUNTERS];
  result_t     pay_item;
  result_t     sum_item;

  always_comb begin
    off   = frame_start ? '0 : byte_offset;
    wl    = frame_start ? frame_length : wire_length;
    et    = frame_start ? '0 : ether_type;
    hw    = frame_start ? '0 : header_words;
    tl_hi = frame_start ? '0 : ip_len_hi;
    src_a = frame_start ? '0 : src_address_reg;
    src_p = frame_start ? '0 : src_port_reg;
    ulen  = frame_start ? '0 : udp_length;
    st    = frame_start ? ST_UDP : frame_status;

    active   = off != OFF_SAT;
    ipv4     = 1'b0;
    udp_live = 1'b0;
    pay      = 1'b0;
    off_next = off;

    if (active && off == OFF_TYPE_HI) et[15:8] = data_byte;
    if (active && off == OFF_TYPE_LO) begin
      et[7:0] = data_byte;
      priority if (et == ETH_IPV4) st = ST_UDP;
      else if (et == ETH_ARP) st = ST_ARP;
      else st = ST_OTHER_ETH;
    end
    ipv4 = active && off > OFF_TYPE_LO && et == ETH_IPV4;
    if (ipv4 && off == OFF_VER_IHL) begin
      hw = data_byte[3:0];
      if (data_byte[7:4] != IP_VERSION4) st = ST_BAD_VER;
      else if (data_byte[3:0] < IP_MIN_WORDS) st = ST_BAD_HLEN;
    end
    hdr = ETH_HDR_BYTES + {10'd0, hw, 2'b00};
    if (ipv4 && off == OFF_TLEN_HI) tl_hi = data_byte;
    if (ipv4 && off == OFF_TLEN_LO && st == ST_UDP && wl < {tl_hi, data_byte}) begin
      st = ST_TRUNC;
    end
    if (ipv4 && off == OFF_PROTO && st == ST_UDP) begin
      unique case (data_byte)
        PROTO_UDP:  st = ST_UDP;
        PROTO_TCP:  st = ST_TCP;
        PROTO_ICMP: st = ST_ICMP;
        default:    st = ST_OTHER_PROTO;
      endcase
    end
    if (ipv4 && off >= OFF_SRC_FIRST && off <= OFF_SRC_LAST) begin
      src_a = {src_a[23:0], data_byte};
    end

    udp_live = ipv4 && off >= OFF_UDP_MIN && st == ST_UDP;
    if (udp_live) begin
      if (off == hdr + UDP_PORT_HI) src_p[15:8] = data_byte;
      if (off == hdr + UDP_PORT_LO) src_p[7:0]  = data_byte;
      if (off == hdr + UDP_LEN_HI)  ulen[15:8]  = data_byte;
      if (off == hdr + UDP_LEN_LO)  ulen[7:0]   = data_byte;
    end
    plen   = (ulen >= UDP_HDR_BYTES) ? ulen - UDP_HDR_BYTES : '0;
    pstart = {1'b0, hdr} + {1'b0, UDP_HDR_BYTES};
    pay    = udp_live && {1'b0, off} >= pstart && {1'b0, off} < pstart + {1'b0, plen};
    if (active) off_next = off + 16'd1;

    // frame end classification
    is_ip = et == ETH_IPV4 && off >= OFF_TYPE_LO;
    priority if (off < OFF_TYPE_LO) fst = ST_RUNT;
    else if (is_ip && off < OFF_SRC_LAST) fst = ST_RUNT;
    else if (is_ip && st == ST_UDP && off < hdr + UDP_LEN_LO) fst = ST_RUNT;
    else fst = st;

    cnt_next[CNT_UDP]     = packet_counters[CNT_UDP]
                            + {31'd0, frame_end && fst == ST_UDP};
    cnt_next[CNT_TCP]     = packet_counters[CNT_TCP]
                            + {31'd0, frame_end && fst == ST_TCP};
    cnt_next[CNT_ICMP]    = packet_counters[CNT_ICMP]
                            + {31'd0, frame_end && fst == ST_ICMP};
    cnt_next[CNT_ARP]     = packet_counters[CNT_ARP]
                            + {31'd0, frame_end && fst == ST_ARP};
    cnt_next[CNT_UNKNOWN] = packet_counters[CNT_UNKNOWN]
                            + {31'd0, frame_end && fst == ST_OTHER_ETH};

    pay_item              = '0;
    pay_item.kind         = KIND_PAYLOAD;
    pay_item.payload_byte = data_byte;
    pay_item.end_of_run   = !frame_end;
    pay_item.status       = ST_UDP;

    sum_item                = '0;
    sum_item.kind           = KIND_SUMMARY;
    sum_item.end_of_run     = 1'b1;
    sum_item.status         = fst;
    sum_item.source_address = (is_ip && fst != ST_RUNT) ? src_a : '0;
    sum_item.source_port    = (fst == ST_UDP) ? src_p : '0;
    sum_item.payload_length = (fst == ST_UDP) ? plen : '0;
    sum_item.udp_total      = cnt_next[CNT_UDP];
    sum_item.tcp_total      = cnt_next[CNT_TCP];
    sum_item.icmp_total     = cnt_next[CNT_ICMP];
    sum_item.arp_total      = cnt_next[CNT_ARP];
    sum_item.unknown_total  = cnt_next[CNT_UNKNOWN];

    push.count   = accept ? ({1'b0, pay} + {1'b0, frame_end}) : 2'd0;
    push.item[0] = pay ? pay_item : sum_item;
    push.item[1] = sum_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset     <= '0;
      wire_length     <= '0;
      ether_type      <= '0;
      header_words    <= '0;
      ip_len_hi       <= '0;
      src_address_reg <= '0;
      src_port_reg    <= '0;
      udp_length      <= '0;
      frame_status    <= ST_UDP;
      for (int i = 0; i < NUM_COUNTERS; i++) packet_counters[i] <= '0;
    end else if (accept) begin
      wire_length <= wl;
      for (int i = 0; i < NUM_COUNTERS; i++) packet_counters[i] <= cnt_next[i];
      if (frame_end) begin
        byte_offset     <= '0;
        ether_type      <= '0;
        header_words    <= '0;
        ip_len_hi       <= '0;
        src_address_reg <= '0;
        src_port_reg    <= '0;
        udp_length      <= '0;
        frame_status    <= ST_UDP;
      end else begin
        byte_offset     <= off_next;
        ether_type      <= et;
        header_words    <= hw;
        ip_len_hi       <= tl_hi;
        src_address_reg <= src_a;
        src_port_reg    <= src_p;
        udp_length      <= ulen;
        frame_status    <= st;
      end
    end
  end

endmodule

// ===== rtl/core/eiup_queue.sv =====
// Result queue: takes up to two items per cycle, delivers one per handshake.
// Entries are registers; the head is read at the read pointer. Depends on eiup_pkg.
module eiup_queue
  import eiup_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  input  logic    ready,
  output result_t head,
  output logic    valid,
  output logic    room
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  result_t        entries [DEPTH];
  logic [PW-1:0]  rd_ptr;
  logic [PW-1:0]  wr_ptr;
  logic [CW-1:0]  count;
  logic [PW-1:0]  rd_ptr_next;
  logic [PW-1:0]  wr_ptr_inc;
  logic [PW-1:0]  wr_ptr_next;
  logic [CW-1:0]  count_next;
  logic           pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign valid = count != '0;
  assign room  = count <= CW'(DEPTH - 2);
  assign pop   = valid && ready;
  assign head  = entries[rd_ptr];

  always_comb begin
    wr_ptr_inc  = ptr_inc(wr_ptr);
    rd_ptr_next = pop ? ptr_inc(rd_ptr) : rd_ptr;
    unique case (push.count)
      2'd0:    wr_ptr_next = wr_ptr;
      2'd1:    wr_ptr_next = wr_ptr_inc;
      default: wr_ptr_next = ptr_inc(wr_ptr_inc);
    endcase
    count_next = count + CW'(push.count) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      rd_ptr <= rd_ptr_next;
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (push.count != 2'd0 && PW'(i) == wr_ptr) entries[i] <= push.item[0];
      if (push.count == 2'd2 && PW'(i) == wr_ptr_inc) entries[i] <= push.item[1];
    end
  end

endmodule

// ===== rtl/core/ethernet_ipv4_udp_parser.sv =====
// Ethernet/IPv4/UDP header parser, top level.
// Uses eiup_parse and eiup_queue; depends on eiup_pkg.
//
// Input stream s_*: one frame byte per item. s_tuser marks the first byte of
// a frame (frame length in s_tdata is taken then), s_tlast the last byte.
// Output stream m_*: m_tuser 0 is a UDP payload byte, 1 a frame summary with
// status, source address/port, payload length and the five packet counters.
// m_tlast is set on the last result caused by one input byte.
// Results of a byte are written into the result queue registers on accept.
// Throughput: one byte per cycle while s_tready is high. A byte can cause
// two results (last payload byte, summary), drained one per cycle on m_tready.
// s_tready is high while at most DEPTH-2 items wait in the result queue, so
// with the default depth of 4 input stalls once three items wait on a stalled
// receiver; bytes that cause no result pass until then.
// No result is dropped while m_tready is low.
// Reset (rst, synchronous) clears frame state, counters and the queue.
module ethernet_ipv4_udp_parser
  import eiup_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [23:0]  s_tdata,   // data_byte[7:0], frame_length[23:8]
  input  logic         s_tlast,   // frame_end
  input  logic         s_tuser,   // frame_start
  output logic         m_tvalid,
  input  logic         m_tready,
  // payload_byte[7:0], status[11:8], source_address[43:12], source_port[59:44],
  // payload_length[75:60], udp_total[107:76], tcp_total[139:108],
  // icmp_total[171:140], arp_total[203:172], unknown_total[235:204], zero pad
  output logic [239:0] m_tdata,
  output logic         m_tlast,   // end_of_run
  output logic         m_tuser    // kind
);

  logic    accept;
  logic    room;
  push_t   push;
  result_t head;

  assign s_tready = room;
  assign accept   = s_tvalid && s_tready;

  eiup_parse u_parse (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .data_byte    (s_tdata[7:0]),
    .frame_start  (s_tuser),
    .frame_end    (s_tlast),
    .frame_length (s_tdata[23:8]),
    .push         (push)
  );

  eiup_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .ready (m_tready),
    .head  (head),
    .valid (m_tvalid),
    .room  (room)
  );

  assign m_tlast = head.end_of_run;
  assign m_tuser = head.kind;
  assign m_tdata = {4'd0, head.unknown_total, head.arp_total, head.icmp_total,
                    head.tcp_total, head.udp_total, head.payload_length,
                    head.source_port, head.source_address, head.status,
                    head.payload_byte};

`ifndef SYNTHESIS
  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("summary item without end_of_run");

  a_summary_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[11:8] <= 4'd9)
    else $error("summary status out of range");

  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[239:8] == '0)
    else $error("payload item carries summary fields");

  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept && s_tlast |=> m_tvalid)
    else $error("frame end produced no result");
`endif

endmodule

// ===== tb/ethernet_ipv4_udp_parser_test.sv =====
// Self-checking bench for ethernet_ipv4_udp_parser: directed and random frames,
// each byte predicted by a header tracker that checks payload and summary items.
// Depends on eiup_pkg and the parser RTL.
`timescale 1ns / 1ps

module ethernet_ipv4_udp_parser_test;
  import eiup_pkg::*;

  localparam int STALL_LIMIT  = 1000;
  localparam int RANDOM_BYTES = 860;

  class header_tracker;
    logic [15:0] offset, wire_len, etype, ip_tlen, src_port, udp_len;
    logic [3:0]  hwords;
    logic [7:0]  proto;
    logic [31:0] src_addr;
    status_t     frame_class;
    logic [31:0] totals [NUM_COUNTERS];
    result_t     awaited[$];
    int          mismatches;

    function new();
      clear_frame();
      wire_len = '0;
      foreach (totals[i]) totals[i] = '0;
      mismatches = 0;
    endfunction

    function void clear_frame();
      offset = '0;
      etype = '0;
      hwords = '0;
      ip_tlen = '0;
      proto = '0;
      src_addr = '0;
      src_port = '0;
      udp_len = '0;
      frame_class = ST_UDP;
    endfunction

    function int udp_payload();
      return (udp_len >= UDP_HDR_BYTES) ? int'(udp_len - UDP_HDR_BYTES) : 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // Predict the items caused by one accepted byte.
    function void take_byte(logic [7:0] b, bit first, bit last, logic [15:0] flen);
      int      off, hdr, pstart;
      bit      ipv4, is_ip;
      status_t st;
      result_t r;
      result_t made[$];
      if (first) begin
        clear_frame();
        wire_len = flen;
      end
      off = offset;
      ipv4 = 1'b0;
      hdr = ETH_HDR_BYTES + 4 * hwords;
      if (off != OFF_SAT) begin
        if (off == OFF_TYPE_HI) etype[15:8] = b;
        if (off == OFF_TYPE_LO) begin
          etype[7:0] = b;
          if (etype == ETH_IPV4) frame_class = ST_UDP;
          else if (etype == ETH_ARP) frame_class = ST_ARP;
          else frame_class = ST_OTHER_ETH;
        end
        ipv4 = off > OFF_TYPE_LO && etype == ETH_IPV4;
        if (ipv4 && off == OFF_VER_IHL) begin
          hwords = b[3:0];
          if (b[7:4] != IP_VERSION4) frame_class = ST_BAD_VER;
          else if (hwords < IP_MIN_WORDS) frame_class = ST_BAD_HLEN;
          hdr = ETH_HDR_BYTES + 4 * hwords;
        end
        if (ipv4 && off == OFF_TLEN_HI) ip_tlen[15:8] = b;
        if (ipv4 && off == OFF_TLEN_LO) begin
          ip_tlen[7:0] = b;
          if (frame_class == ST_UDP && wire_len < ip_tlen) frame_class = ST_TRUNC;
        end
        if (ipv4 && off == OFF_PROTO) begin
          proto = b;
          if (frame_class == ST_UDP) begin
            case (b)
              PROTO_UDP:  frame_class = ST_UDP;
              PROTO_TCP:  frame_class = ST_TCP;
              PROTO_ICMP: frame_class = ST_ICMP;
              default:    frame_class = ST_OTHER_PROTO;
            endcase
          end
        end
        if (ipv4 && off >= OFF_SRC_FIRST && off <= OFF_SRC_LAST)
          src_addr = {src_addr[23:0], b};
        if (ipv4 && off >= OFF_UDP_MIN && frame_class == ST_UDP) begin
          if (off == hdr + UDP_PORT_HI) src_port[15:8] = b;
          if (off == hdr + UDP_PORT_LO) src_port[7:0] = b;
          if (off == hdr + UDP_LEN_HI) udp_len[15:8] = b;
          if (off == hdr + UDP_LEN_LO) udp_len[7:0] = b;
          pstart = hdr + UDP_HDR_BYTES;
          if (off >= pstart && off < pstart + udp_payload()) begin
            r = '0;
            r.kind = KIND_PAYLOAD;
            r.payload_byte = b;
            r.status = ST_UDP;
            made.push_back(r);
          end
        end
        offset = 16'(off + 1);
      end
      if (last) begin
        st = frame_class;
        is_ip = etype == ETH_IPV4 && off >= OFF_TYPE_LO;
        if (off < OFF_TYPE_LO) st = ST_RUNT;
        else if (is_ip && off < OFF_SRC_LAST) st = ST_RUNT;
        else if (is_ip && st == ST_UDP && off < hdr + UDP_LEN_LO) st = ST_RUNT;
        case (st)
          ST_UDP:       totals[CNT_UDP]++;
          ST_TCP:       totals[CNT_TCP]++;
          ST_ICMP:      totals[CNT_ICMP]++;
          ST_ARP:       totals[CNT_ARP]++;
          ST_OTHER_ETH: totals[CNT_UNKNOWN]++;
          default: ;
        endcase
        r = '0;
        r.kind = KIND_SUMMARY;
        r.status = st;
        r.source_address = (is_ip && st != ST_RUNT) ? src_addr : '0;
        r.source_port = (st == ST_UDP) ? src_port : '0;
        r.payload_length = (st == ST_UDP) ? 16'(udp_payload()) : '0;
        r.udp_total = totals[CNT_UDP];
        r.tcp_total = totals[CNT_TCP];
        r.icmp_total = totals[CNT_ICMP];
        r.arp_total = totals[CNT_ARP];
        r.unknown_total = totals[CNT_UNKNOWN];
        made.push_back(r);
        clear_frame();
      end
      if (made.size() > 0) made[made.size() - 1].end_of_run = 1'b1;
      foreach (made[i]) awaited.push_back(made[i]);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got === want) return;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    endfunction

    function void match_result(logic [239:0] d, logic last, logic user);
      result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual kind %0b data %0h",
                 $time, user, d);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      compare_field("kind", want.kind, user);
      compare_field("end_of_run", want.end_of_run, last);
      compare_field("payload_byte", want.payload_byte, d[7:0]);
      compare_field("status", want.status, d[11:8]);
      compare_field("source_address", want.source_address, d[43:12]);
      compare_field("source_port", want.source_port, d[59:44]);
      compare_field("payload_length", want.payload_length, d[75:60]);
      compare_field("udp_total", want.udp_total, d[107:76]);
      compare_field("tcp_total", want.tcp_total, d[139:108]);
      compare_field("icmp_total", want.icmp_total, d[171:140]);
      compare_field("arp_total", want.arp_total, d[203:172]);
      compare_field("unknown_total", want.unknown_total, d[235:204]);
    endfunction
  endclass

  logic         clk;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [23:0]  s_tdata = '0;
  logic         s_tlast = 1'b0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [239:0] m_tdata;
  logic         m_tlast;
  logic         m_tuser;

  header_tracker tracker = new();
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  int bytes_sent = 0;
  int idle_cycles = 0;

  ethernet_ipv4_udp_parser dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tlast(s_tlast), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // result sink with random back-pressure
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = rx_quiet ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      tracker.match_result(m_tdata, m_tlast, m_tuser);
    end
  end

  task automatic send_byte(logic [7:0] b, bit first, bit last, logic [15:0] flen);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {flen, b};
    s_tlast <= last;
    s_tuser <= first;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.take_byte(b, first, last, flen);
    bytes_sent++;
  endtask

  task automatic send_frame(ref logic [7:0] q[$], input logic [15:0] flen,
                            input bit with_start, input bit with_end);
    for (int i = 0; i < q.size(); i++)
      send_byte(q[i], with_start && i == 0, with_end && i == q.size() - 1,
                (i == 0) ? flen : 16'($urandom));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() > 0) @(posedge clk);
  endtask

  function automatic void build_eth(ref logic [7:0] q[$], input logic [15:0] ethertype,
                                    input int body);
    q.delete();
    repeat (12) q.push_back(8'($urandom));
    q.push_back(ethertype[15:8]);
    q.push_back(ethertype[7:0]);
    repeat (body) q.push_back(8'($urandom));
  endfunction

  // IPv4 frame; the 8 bytes after the IP header always carry a UDP-style header
  function automatic void build_ipv4(ref logic [7:0] q[$], input logic [7:0] ver_ihl,
                                     input logic [7:0] ip_proto, input logic [15:0] tlen,
                                     input logic [15:0] ulen, input int body);
    build_eth(q, ETH_IPV4, 0);
    q.push_back(ver_ihl);
    q.push_back(8'($urandom));
    q.push_back(tlen[15:8]);
    q.push_back(tlen[7:0]);
    repeat (5) q.push_back(8'($urandom));
    q.push_back(ip_proto);
    repeat (10) q.push_back(8'($urandom));
    if (ver_ihl[3:0] > IP_MIN_WORDS)
      repeat (4 * (int'(ver_ihl[3:0]) - 5)) q.push_back(8'($urandom));
    repeat (4) q.push_back(8'($urandom));
    q.push_back(ulen[15:8]);
    q.push_back(ulen[7:0]);
    repeat (2 + body) q.push_back(8'($urandom));
  endfunction

  function automatic void cut_to(ref logic [7:0] q[$], input int n);
    while (q.size() > n) void'(q.pop_back());
  endfunction

  task automatic directed_frames();
    logic [7:0] q[$];
    logic [7:0] protos[4];
    logic [7:0] bad_hdr[4];
    protos = '{PROTO_TCP, PROTO_ICMP, 8'hFF, 8'h00};
    bad_hdr = '{8'h65, 8'hF5, 8'h40, 8'h44};
    // no frame_start right after reset
    build_eth(q, ETH_ARP, 14);
    send_frame(q, 16'h0000, 1'b0, 1'b1);
    build_ipv4(q, 8'h45, PROTO_UDP, 16'd34, 16'd14, 6);
    send_frame(q, 16'(q.size()), 1'b1, 1'b1);
    build_ipv4(q, 8'h4F, PROTO_UDP, 16'd71, 16'd11, 3);
    send_frame(q, 16'(q.size()), 1'b1, 1'b1);
    // UDP length below the header size
    build_ipv4(q, 8'h45, PROTO_UDP, 16'd33, 16'd3, 5);
    send_frame(q, 16'(q.size()), 1'b1, 1'b1);
    build_ipv4(q, 8'h45, PROTO_UDP, 16'd28, 16'd8, 2);
    send_frame(q, 16'(q.size()), 1'b1, 1'b1);
    // frame ends inside the payload
    build_ipv4(q, 8'h45, PROTO_UDP, 16'd35, 16'd28, 7);
    send_frame(q, 16'(q.size()), 1'b1, 1'b1);
    // ends one byte before the UDP length is complete, then exactly on it
    build_ipv4(q, 8'h45, PROTO_UDP, 16'd28, 16'd16, 8);
    cut_to(q, 39);
    send_frame(q, 16'(q.size()), 1'b1, 1'b1);
    build_ipv4(q, 8'h45, PROTO_UDP, 16'd28, 16'd16, 8);
    cut_to(q, 40);
    send_frame(q, 16'(q.size()), 1'b1, 1'b1);
    foreach (protos[i]) begin
      build_ipv4(q, 8'h45, protos[i], 16'd30, 16'd10, 2);
      send_frame(q, 16'(q.size()), 1'b1, 1'b1);
    end
    build_eth(q, 16'hFFFF, 20);
    send_frame(q, 16'hFFFF, 1'b1, 1'b1);
    build_eth(q, 16'h0000, 0);
    send_frame(q, 16'(q.size()), 1'b1, 1'b1);
    build_eth(q, ETH_ARP, 0);
    send_frame(q, 16'(q.size()), 1'b1, 1'b1);
    foreach (bad_hdr[i]) begin
      build_ipv4(q, bad_hdr[i], PROTO_UDP, 16'd30, 16'd10, 2);
      send_frame(q, 16'(q.size()), 1'b1, 1'b1);
    end
    // IP total length above the wire length
    build_ipv4(q, 8'h45, PROTO_UDP, 16'hFFFF, 16'd12, 4);
    send_frame(q, 16'(q.size()), 1'b1, 1'b1);
    // runts: one byte, before the ethertype ends, before the source address ends
    send_byte(8'hFF, 1'b1, 1'b1, 16'hFFFF);
    build_eth(q, ETH_ARP, 0);
    cut_to(q, 13);
    send_frame(q, 16'd13, 1'b1, 1'b1);
    build_ipv4(q, 8'h45, PROTO_UDP, 16'd28, 16'd8, 0);
    cut_to(q, 29);
    send_frame(q, 16'd29, 1'b1, 1'b1);
    // restart inside a frame, then a frame without start after a clean end
    build_ipv4(q, 8'h45, PROTO_UDP, 16'd30, 16'd10, 2);
    cut_to(q, 20);
    send_frame(q, 16'd100, 1'b1, 1'b0);
    build_ipv4(q, 8'h45, PROTO_UDP, 16'd31, 16'd11, 3);
    send_frame(q, 16'(q.size()), 1'b1, 1'b1);
    build_ipv4(q, 8'h45, PROTO_UDP, 16'd31, 16'd11, 3);
    send_frame(q, 16'h1234, 1'b0, 1'b1);
    drain();
  endtask

  task automatic random_frame();
    logic [7:0]  q[$];
    int          pick, ihl, n;
    logic [15:0] ulen, tlen, flen, ethertype;
    logic [7:0]  ip_proto, vi;
    bit          with_start, with_end;
    pick = $urandom_range(0, 9);
    if (pick == 8) begin
      repeat ($urandom_range(1, 40))
        send_byte(8'($urandom), $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0,
                  16'($urandom));
    end else begin
      ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
      n = $urandom_range(0, 12);
      ulen = 16'(8 + n);
      if ($urandom_range(0, 5) == 0) ulen = 16'($urandom_range(0, 30));
      tlen = 16'(4 * ihl + 8 + n);
      vi = {IP_VERSION4, 4'(ihl)};
      ip_proto = PROTO_UDP;
      if (pick == 5) begin
        case ($urandom_range(0, 2))
          0: ip_proto = PROTO_TCP;
          1: ip_proto = PROTO_ICMP;
          default: ip_proto = 8'($urandom);
        endcase
      end
      if (pick == 7) begin
        if ($urandom_range(0, 1) == 1) vi = 8'($urandom);
        else tlen = 16'($urandom);
      end
      if (pick == 6) begin
        ethertype = ($urandom_range(0, 1) == 1) ? ETH_ARP : 16'($urandom);
        build_eth(q, ethertype, $urandom_range(0, 30));
      end else begin
        build_ipv4(q, vi, ip_proto, tlen, ulen, n);
      end
      if (pick == 9) cut_to(q, $urandom_range(1, q.size()));
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 4)) q.push_back(8'($urandom));
      flen = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'(q.size());
      with_start = $urandom_range(0, 15) != 0;
      with_end = $urandom_range(0, 15) != 0;
      send_frame(q, flen, with_start, with_end);
    end
  endtask

  initial begin
    int base;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    directed_frames();
    base = bytes_sent;
    while (bytes_sent - base < RANDOM_BYTES) begin
      tx_quiet = $urandom_range(0, 5) == 0;
      rx_quiet = $urandom_range(0, 5) == 0;
      random_frame();
      if ($urandom_range(0, 9) == 0) drain();
    end
    drain();
    repeat (20) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/eiup_pkg.sv
rtl/core/eiup_parse.sv
rtl/core/eiup_queue.sv
rtl/core/ethernet_ipv4_udp_parser.sv
tb/ethernet_ipv4_udp_parser_test.sv
